/* sv/prtt_pkg.sv */
package prtt_pkg;

  localparam int TableEntriesDefault = 64;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_OLDEST = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
  } ctl_sts_t;

  // One stored entry: page, packed log position, error, three times.
  typedef struct packed {
    logic [31:0] page;
    logic [62:0] lpos;
    logic [31:0] err;
    logic [63:0] t_before;
    logic [63:0] t_on_page;
    logic [63:0] t_after;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

/* sv/prtt_ctrl.sv */
module prtt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  prtt_pkg::ctl_sts_t  sts,
  output prtt_pkg::ctl_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);

  prtt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prtt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      prtt_pkg::ST_IDLE: if (in_fire) state_next = prtt_pkg::ST_SCAN;
      prtt_pkg::ST_SCAN: if (sts.scan_last) state_next = prtt_pkg::ST_DONE;
      prtt_pkg::ST_DONE: state_next = prtt_pkg::ST_OUT;
      prtt_pkg::ST_OUT:  if (out_fire) state_next = prtt_pkg::ST_IDLE;
      default:           state_next = prtt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state)
      prtt_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      prtt_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      prtt_pkg::ST_DONE: cmd.commit = 1'b1;
      prtt_pkg::ST_OUT: begin
        out_valid = 1'b1;
        cmd.emit = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

/* sv/prtt_dpath.sv */
module prtt_dpath #(
  parameter int TABLE_ENTRIES = prtt_pkg::TableEntriesDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  prtt_pkg::ctl_cmd_t         cmd,
  output prtt_pkg::ctl_sts_t         sts,
  input  logic [1:0]                 in_command,
  input  logic [31:0]                in_page_start,
  input  logic [31:0]                in_page_end,
  input  prtt_pkg::entry_t           in_entry,
  output logic                       status,
  output logic                       page_present,
  output logic                       any_present,
  output prtt_pkg::entry_t           oldest,
  output logic [6:0]                 entry_count
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  // Page number and payload share one entry, so the scan reads a whole slot
  // through a single registered read port.
  prtt_pkg::entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  prtt_pkg::cmd_t    op;
  logic [31:0]       p_start, p_end;
  prtt_pkg::entry_t  req;

  logic [IdxW-1:0]   rd_idx;     // issue address, one ahead of the compare
  logic              rd_ok;
  logic [IdxW-1:0]   cmp_idx;
  prtt_pkg::entry_t  rd_data;

  logic              found;
  logic              have_free;
  logic [IdxW-1:0]   free_idx;
  logic              have_best;
  prtt_pkg::entry_t  best;
  logic [CntW-1:0]   count;

  logic              cmp_valid;
  logic              in_range;
  logic              better;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= prtt_pkg::cmd_t'(in_command);
      p_start <= in_page_start;
      p_end   <= in_page_end;
      req     <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    if (cmd.commit && op == prtt_pkg::CMD_SET && !found && have_free) begin
      mem[free_idx] <= req;
    end
  end

  assign cmp_valid = valid[cmp_idx];
  assign in_range  = rd_data.page >= p_start && rd_data.page <= p_end;
  assign better    = !have_best || rd_data.lpos < best.lpos ||
                     (rd_data.lpos == best.lpos && rd_data.page < best.page);
  assign sts.scan_last = rd_ok && (cmp_idx == IdxW'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      rd_idx <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx <= '0;
        rd_ok  <= 1'b0;
        cmp_idx <= '0;
        found <= 1'b0;
        have_free <= 1'b0;
        have_best <= 1'b0;
        best <= '0;
      end else if (cmd.scan_step) begin
        if (!rd_ok) begin
          rd_ok  <= 1'b1;
          rd_idx <= IdxW'(1);
        end else begin
          rd_idx  <= rd_idx + 1'b1;
          cmp_idx <= cmp_idx + 1'b1;
          if (cmp_valid) begin
            if (rd_data.page == p_start) found <= 1'b1;
            if (op == prtt_pkg::CMD_CLEAR && in_range) begin
              valid[cmp_idx] <= 1'b0;
              count <= count - 1'b1;
            end
            if (op == prtt_pkg::CMD_OLDEST && better) begin
              have_best <= 1'b1;
              best <= rd_data;
            end
          end else if (!have_free) begin
            have_free <= 1'b1;
            free_idx  <= cmp_idx;
          end
        end
      end else if (cmd.commit) begin
        rd_idx <= '0;
        if (op == prtt_pkg::CMD_SET && !found && have_free) begin
          valid[free_idx] <= 1'b1;
          count <= count + 1'b1;
        end
      end
    end
  end

  assign status       = (op == prtt_pkg::CMD_SET) && !found && !have_free;
  assign page_present = (op == prtt_pkg::CMD_QUERY) && found;
  assign any_present  = count != '0;
  assign oldest       = (op == prtt_pkg::CMD_OLDEST && have_best) ? best : '0;
  assign entry_count  = 7'(count);

endmodule

/* sv/page_redo_tracking_table.sv */
// Page redo tracking table.
// Input stream (s_axis_*): one command per transaction; tdata carries
// page_start, page_end, position, error code and three times, tuser the
// command (set, clear range, query, oldest). Output stream (m_axis_*): one
// result per command; tdata carries page_present, any_present, the oldest
// entry and entry_count, tuser the full status of a set.
// Every command walks the whole table through one registered memory read
// port, one slot a cycle, and one command is in flight at a time.
// The result register holds until taken; while the receiver stalls the block
// accepts no new command.
// A synchronous reset empties the table (all valid bits cleared); stored
// payload is never read before it is written.
module page_redo_tracking_table #(
  parameter int TABLE_ENTRIES = prtt_pkg::TableEntriesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // page_start[31:0], page_end[63:32], log_generation[94:64],
  // log_sector[110:95], log_byte[126:111], entry_error[158:127],
  // time_before[222:159], time_on_page[286:223], time_after[350:287], zeros
  input  logic [351:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // page_present[0], any_present[1], oldest_page[33:2],
  // oldest_generation[64:34], oldest_sector[80:65], oldest_byte[96:81],
  // oldest_error[128:97], oldest_time_before[192:129],
  // oldest_time_on_page[256:193], oldest_time_after[320:257],
  // entry_count[327:321]
  output logic [327:0] m_axis_tdata,
  // status[0]
  output logic         m_axis_tuser
);

  prtt_pkg::ctl_cmd_t cmd;
  prtt_pkg::ctl_sts_t sts;
  prtt_pkg::entry_t   in_entry, oldest;
  logic busy, in_fire, out_fire;
  logic page_present, any_present;
  logic [6:0] entry_count;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign in_entry.page      = s_axis_tdata[31:0];
  assign in_entry.lpos      = {s_axis_tdata[94:64], s_axis_tdata[110:95],
                               s_axis_tdata[126:111]};
  assign in_entry.err       = s_axis_tdata[158:127];
  assign in_entry.t_before  = s_axis_tdata[222:159];
  assign in_entry.t_on_page = s_axis_tdata[286:223];
  assign in_entry.t_after   = s_axis_tdata[350:287];

  prtt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
  );

  prtt_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_command(s_axis_tuser), .in_page_start(s_axis_tdata[31:0]),
    .in_page_end(s_axis_tdata[63:32]), .in_entry(in_entry),
    .status(m_axis_tuser), .page_present(page_present),
    .any_present(any_present), .oldest(oldest), .entry_count(entry_count)
  );

  assign m_axis_tdata = {entry_count, oldest.t_after, oldest.t_on_page,
                         oldest.t_before, oldest.err, oldest.lpos[15:0],
                         oldest.lpos[31:16], oldest.lpos[62:32], oldest.page,
                         any_present, page_present};

endmodule

/* sv/prtt_checker.sv */
module prtt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [327:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("command accepted while a result is pending");

  a_any: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1] == (m_axis_tdata[327:321] != 7'd0)))
    else $error("any_present disagrees with entry_count");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser && m_axis_tdata[0]))
    else $error("full status and page_present both set");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

endmodule

bind page_redo_tracking_table prtt_checker u_prtt_checker (
  .clk(clk), .rst(rst),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);

/* tb/tb_page_redo_tracking_table.sv */
`timescale 1ns / 100ps

module tb_page_redo_tracking_table;

  localparam int Slots = 64;
  localparam int CycleLimit = 1000000;

  typedef struct {
    prtt_pkg::cmd_t cmd;
    logic [31:0] page_start;
    logic [31:0] page_end;
    logic [30:0] gen;
    logic [15:0] sector;
    logic [15:0] byte_ofs;
    logic [31:0] err;
    logic [63:0] t_before;
    logic [63:0] t_on_page;
    logic [63:0] t_after;
  } command_t;

  typedef struct {
    logic        status;
    logic        present;
    logic        any;
    logic [31:0] page;
    logic [30:0] gen;
    logic [15:0] sector;
    logic [15:0] byte_ofs;
    logic [31:0] err;
    logic [63:0] t_before;
    logic [63:0] t_on_page;
    logic [63:0] t_after;
    logic [6:0]  count;
  } answer_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [327:0] m_axis_tdata;
  logic         m_axis_tuser;

  page_redo_tracking_table dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Shadow copy of the table.
  logic        shadow_valid [Slots];
  logic [31:0] shadow_page [Slots];
  logic [62:0] shadow_lpos [Slots];
  logic [31:0] shadow_err [Slots];
  logic [63:0] shadow_tb [Slots];
  logic [63:0] shadow_tp [Slots];
  logic [63:0] shadow_ta [Slots];

  command_t pending_cmds[$];
  answer_t  expected_answers[$];
  int       errors = 0;
  int       cycles = 0;
  int       accepted = 0;
  int       answers_seen = 0;
  int       hold_left = 0;
  bit       hold_done = 0;
  logic     in_fire = 0;

  function automatic answer_t table_step(command_t c);
    answer_t a;
    int hit, free_idx, best, n;
    a = '{default: '0};
    hit = -1;
    free_idx = -1;
    best = -1;
    n = 0;
    for (int i = 0; i < Slots; i++) begin
      if (shadow_valid[i] && shadow_page[i] == c.page_start && hit < 0) hit = i;
      if (!shadow_valid[i] && free_idx < 0) free_idx = i;
    end
    case (c.cmd)
      prtt_pkg::CMD_SET: begin
        if (hit < 0) begin
          if (free_idx < 0) begin
            a.status = 1'b1;
          end else begin
            shadow_valid[free_idx] = 1'b1;
            shadow_page[free_idx] = c.page_start;
            shadow_lpos[free_idx] = {c.gen, c.sector, c.byte_ofs};
            shadow_err[free_idx] = c.err;
            shadow_tb[free_idx] = c.t_before;
            shadow_tp[free_idx] = c.t_on_page;
            shadow_ta[free_idx] = c.t_after;
          end
        end
      end
      prtt_pkg::CMD_CLEAR: begin
        for (int i = 0; i < Slots; i++)
          if (shadow_page[i] >= c.page_start && shadow_page[i] <= c.page_end)
            shadow_valid[i] = 1'b0;
      end
      prtt_pkg::CMD_QUERY: a.present = (hit >= 0);
      default: begin
        for (int i = 0; i < Slots; i++) begin
          if (shadow_valid[i] && (best < 0 || shadow_lpos[i] < shadow_lpos[best] ||
              (shadow_lpos[i] == shadow_lpos[best] && shadow_page[i] < shadow_page[best])))
            best = i;
        end
        if (best >= 0) begin
          a.page = shadow_page[best];
          {a.gen, a.sector, a.byte_ofs} = shadow_lpos[best];
          a.err = shadow_err[best];
          a.t_before = shadow_tb[best];
          a.t_on_page = shadow_tp[best];
          a.t_after = shadow_ta[best];
        end
      end
    endcase
    for (int i = 0; i < Slots; i++) if (shadow_valid[i]) n++;
    a.any = (n != 0);
    a.count = n[6:0];
    return a;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic command_t make_cmd(prtt_pkg::cmd_t op, logic [31:0] ps,
                                        logic [31:0] pe);
    command_t c;
    c.cmd = op;
    c.page_start = ps;
    c.page_end = pe;
    if ($urandom_range(0, 3) == 0) begin
      c.gen = 31'($urandom);
      c.sector = 16'($urandom);
      c.byte_ofs = 16'($urandom);
    end else begin
      // Narrow positions so that ties and near ties are common.
      c.gen = 31'($urandom_range(0, 3));
      c.sector = 16'($urandom_range(0, 3));
      c.byte_ofs = 16'($urandom_range(0, 3));
    end
    c.err = $urandom;
    c.t_before = rand64();
    c.t_on_page = rand64();
    c.t_after = rand64();
    return c;
  endfunction

  function automatic logic [31:0] rand_page();
    if ($urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 9) == 0) return 32'hFFFF_FFFF - $urandom_range(0, 15);
    return $urandom_range(0, 95);
  endfunction

  function automatic command_t rand_cmd();
    int pick;
    logic [31:0] ps;
    pick = $urandom_range(0, 99);
    ps = rand_page();
    if (pick < 45) return make_cmd(prtt_pkg::CMD_SET, ps, $urandom);
    if (pick < 55) begin
      if ($urandom_range(0, 19) == 0)
        return make_cmd(prtt_pkg::CMD_CLEAR, 32'd0, 32'hFFFF_FFFF);
      if ($urandom_range(0, 9) == 0) return make_cmd(prtt_pkg::CMD_CLEAR, ps, $urandom);
      return make_cmd(prtt_pkg::CMD_CLEAR, ps, ps + $urandom_range(0, 8));
    end
    if (pick < 78) return make_cmd(prtt_pkg::CMD_QUERY, ps, $urandom);
    return make_cmd(prtt_pkg::CMD_OLDEST, $urandom, $urandom);
  endfunction

  task automatic wait_drained();
    @(posedge clk);
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("page_redo_tracking_table: mismatch");
      $finish;
    end
  end

  // Sender: offers the oldest pending command.
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (pending_cmds.size() != 0 &&
          ((accepted > 500 && accepted < 800) || $urandom_range(0, 99) >= 7)) begin
        command_t c;
        c = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.cmd;
        s_axis_tdata <= {1'b0, c.t_after, c.t_on_page, c.t_before, c.err,
                         c.byte_ofs, c.sector, c.gen, c.page_end, c.page_start};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  always @(negedge clk) begin
    if (answers_seen == 300 && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 800;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (accepted > 500 && accepted < 800) || $urandom_range(0, 99) >= 7;
    end
  end

  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      command_t c;
      c.cmd = prtt_pkg::cmd_t'(s_axis_tuser);
      {c.t_after, c.t_on_page, c.t_before, c.err, c.byte_ofs, c.sector, c.gen,
       c.page_end, c.page_start} = s_axis_tdata[350:0];
      expected_answers.push_back(table_step(c));
      accepted <= accepted + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      answers_seen <= answers_seen + 1;
      if (expected_answers.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        check_field("status", 64'(e.status), 64'(m_axis_tuser));
        check_field("page_present", 64'(e.present), 64'(m_axis_tdata[0]));
        check_field("any_present", 64'(e.any), 64'(m_axis_tdata[1]));
        check_field("oldest_page", 64'(e.page), 64'(m_axis_tdata[33:2]));
        check_field("oldest_generation", 64'(e.gen), 64'(m_axis_tdata[64:34]));
        check_field("oldest_sector", 64'(e.sector), 64'(m_axis_tdata[80:65]));
        check_field("oldest_byte", 64'(e.byte_ofs), 64'(m_axis_tdata[96:81]));
        check_field("oldest_error", 64'(e.err), 64'(m_axis_tdata[128:97]));
        check_field("oldest_time_before", e.t_before, m_axis_tdata[192:129]);
        check_field("oldest_time_on_page", e.t_on_page, m_axis_tdata[256:193]);
        check_field("oldest_time_after", e.t_after, m_axis_tdata[320:257]);
        check_field("entry_count", 64'(e.count), 64'(m_axis_tdata[327:321]));
      end
    end
  end

  initial begin
    command_t c;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = prtt_pkg::CMD_SET;
    m_axis_tready = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_page[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, page zero and all-ones page, extreme positions.
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_QUERY, 32'd0, 32'd0));
    c = make_cmd(prtt_pkg::CMD_SET, 32'hFFFF_FFFF, 32'd0);
    c.gen = '1; c.sector = '1; c.byte_ofs = '1;
    c.err = 32'h8000_0000; c.t_before = 64'h8000_0000_0000_0000;
    c.t_on_page = '1; c.t_after = 64'h7FFF_FFFF_FFFF_FFFF;
    pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    c = make_cmd(prtt_pkg::CMD_SET, 32'd0, 32'd0);
    c.gen = '1; c.sector = '1; c.byte_ofs = '1;
    pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    c = make_cmd(prtt_pkg::CMD_SET, 32'd0, 32'd0);
    c.gen = '0; c.sector = '0; c.byte_ofs = '0;
    pending_cmds.push_back(c);  // duplicate set keeps the old entry
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'd0));
    // Start above end.
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_QUERY, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_CLEAR, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_QUERY, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_CLEAR, 32'd0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    wait_drained();

    // Fill the table past capacity, then probe it and clear a range of it.
    for (int i = 0; i < Slots + 4; i++)
      pending_cmds.push_back(make_cmd(prtt_pkg::CMD_SET, 32'd1000 + i, $urandom));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_QUERY, 32'd1000 + Slots, 32'd0));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_CLEAR, 32'd1000, 32'd1031));
    pending_cmds.push_back(make_cmd(prtt_pkg::CMD_OLDEST, 32'd0, 32'd0));
    wait_drained();

    for (int i = 0; i < 1300; i++) begin
      pending_cmds.push_back(rand_cmd());
      if (i == 650) wait_drained();
    end
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("page_redo_tracking_table: match");
    end else begin
      $display("page_redo_tracking_table: mismatch");
    end
    $finish;
  end

endmodule
